FILE: rtl/order_statistic_set_defines.svh
// Assertion macros shared by the order statistic set RTL.
// Used by ost_cell.sv and order_statistic_set.sv; expects clk and rst_n in scope.
`ifndef ORDER_STATISTIC_SET_DEFINES_SVH
`define ORDER_STATISTIC_SET_DEFINES_SVH

// Check a full property on every clock edge outside reset.
`define OST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("order statistic set check failed");

// Check that a condition implies another in the same cycle.
`define OST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order statistic set check failed");

`endif

FILE: rtl/ost_pkg.sv
// Shared types and constants for the order statistic set.
// No dependencies; imported by every other file of the block but the defines header.
package ost_pkg;

    localparam int unsigned KEY_W       = 32;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned ST_W        = 2;
    localparam int unsigned CAP_DEFAULT = 1024;
    localparam int unsigned GROUP       = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_COUNT  = 2'd2,
        CMD_SELECT = 2'd3
    } ost_cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } ost_status_t;

    // Per-cell contribution, combined by OR across the chain.
    typedef struct packed {
        logic             present;
        logic             sel_ok;
        logic [KEY_W-1:0] ans;
    } ost_red_t;

    // Update strobes broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } ost_ctrl_t;

endpackage

FILE: rtl/ost_in_if.sv
// Command channel: valid/ready handshake carrying one command item.
// Depends on ost_pkg.
interface ost_in_if import ost_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink (input valid, input cmd, input key, output ready);
endinterface

FILE: rtl/ost_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on ost_pkg.
interface ost_out_if import ost_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] answer;
    logic [ST_W-1:0]         status;

    modport source (output valid, output answer, output status, input ready);
    modport sink (input valid, input answer, input status, output ready);
endinterface

FILE: rtl/ost_cell.sv
// One slot of the sorted key chain: holds a key, compares it with the probe,
// shifts toward a neighbor on insert or delete. Depends on ost_pkg.
`include "order_statistic_set_defines.svh"

module ost_cell import ost_pkg::*; #(
    parameter int unsigned INDEX = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ost_ctrl_t               ctrl,
    input  ost_cmd_t                cmd,
    input  logic signed [KEY_W-1:0] probe,
    input  logic                    left_valid,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic                    left_lt,
    input  logic                    right_valid,
    input  logic signed [KEY_W-1:0] right_key,
    output logic                    valid_reg,
    output logic signed [KEY_W-1:0] key_reg,
    output logic                    lt,
    output ost_red_t                red
);

    logic                    valid_next;
    logic signed [KEY_W-1:0] key_next;
    logic                    eq;
    logic                    boundary;
    logic                    hit;

    assign lt       = valid_reg && (key_reg < probe);
    assign eq       = valid_reg && (key_reg == probe);
    assign boundary = left_lt && !lt;
    assign hit      = (cmd == CMD_SELECT) && valid_reg
                      && (probe == $signed(KEY_W'(INDEX + 1)));

    always_comb
    begin
        red.present = eq;
        red.sel_ok  = hit;
        if ((cmd == CMD_COUNT) && boundary)
        begin
            red.ans = KEY_W'(INDEX);
        end
        else if (hit)
        begin
            red.ans = key_reg;
        end
        else
        begin
            red.ans = '0;
        end
    end

    // Insert: hold below the slot, take the probe at it, take left above it.
    // Delete: hold below the slot, take right from it upward.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctrl.ins && !lt)
        begin
            if (left_lt)
            begin
                valid_next = 1'b1;
                key_next   = probe;
            end
            else
            begin
                valid_next = left_valid;
                key_next   = left_key;
            end
        end
        else if (ctrl.del && !lt)
        begin
            valid_next = right_valid;
            key_next   = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    `OST_ASSERT_IMP(a_prefix, valid_reg, left_valid)
    `OST_ASSERT_IMP(a_sorted, (INDEX != 0) && valid_reg, left_key < key_reg)
    `OST_ASSERT(a_hold, !(ctrl.ins || ctrl.del) |=> $stable(valid_reg))

endmodule

FILE: rtl/ost_group.sv
// Registered OR reduction over a group of contributions: cells, or the group sums.
// Depends on ost_pkg.
module ost_group import ost_pkg::*; #(
    parameter int unsigned NUM = GROUP
) (
    input  logic                 clk,
    input  ost_red_t [NUM-1:0]   parts,
    output ost_red_t             sum_reg
);

    ost_red_t sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int unsigned i = 0; i < NUM; i++)
        begin
            sum_next = sum_next | parts[i];
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

endmodule

FILE: rtl/order_statistic_set.sv
// Order statistic set: sorted chain of key cells with rank and select queries.
// Depends on ost_pkg, ost_in_if, ost_out_if, ost_cell, ost_group.
//
//  channel  dir  payload                         handshake
//  -------  ---  ------------------------------  ---------------------
//  req      in   cmd[1:0], key[31:0] signed      req.valid & req.ready
//  rsp      out  answer[31:0] signed, status[1:0] rsp.valid & rsp.ready
//
// An item is latched on acceptance in S_IDLE; in S_SCAN the cells compare
// and the group OR registers capture; in S_REDUCE the top OR register
// captures; in S_APPLY the chain updates and the result register loads.
// The two-level registered OR tree sets this sequence; ready is S_IDLE only.
// Reset clears the cell valid bits, the sequencer and the result valid;
// there is no clearing pass. A waiting result does not block acceptance;
// an item that needs the result register holds in S_APPLY until it
// frees.
`include "order_statistic_set_defines.svh"

module order_statistic_set import ost_pkg::*; #(
    parameter int unsigned CAPACITY = CAP_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ost_in_if.sink    req,
    ost_out_if.source rsp
);

    localparam int unsigned NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_REDUCE = 4'b0100,
        S_APPLY  = 4'b1000
    } ost_state_t;

    ost_state_t              state_reg, state_next;
    ost_cmd_t                cmd_reg;
    logic signed [KEY_W-1:0] probe_reg;

    logic                    cell_valid [CAPACITY];
    logic signed [KEY_W-1:0] cell_key   [CAPACITY];
    logic                    cell_lt    [CAPACITY];

    ost_red_t [NGROUP*GROUP-1:0] red_all;
    ost_red_t [NGROUP:0]         grp_sum;
    ost_red_t                    tail_reg, tail_next;
    ost_red_t                    total;

    ost_ctrl_t               ctrl;
    logic                    full;
    logic                    need_out;
    logic                    out_free;
    logic                    advance;
    logic                    accept;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic signed [KEY_W-1:0] answer_reg, answer_next;
    ost_status_t             status_reg, status_next;

    // ---------------------------------------------------------------
    // Cell chain: cell 0 holds the smallest key
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    lv, rv, llt;
        logic signed [KEY_W-1:0] lk, rk;

        if (i == 0)
        begin : g_first
            assign lv  = 1'b1;
            assign lk  = '0;
            assign llt = 1'b1;
        end
        else
        begin : g_mid_left
            assign lv  = cell_valid[i-1];
            assign lk  = cell_key[i-1];
            assign llt = cell_lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rk = '0;
        end
        else
        begin : g_mid_right
            assign rv = cell_valid[i+1];
            assign rk = cell_key[i+1];
        end

        ost_cell #(
            .INDEX(i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmd        (cmd_reg),
            .probe      (probe_reg),
            .left_valid (lv),
            .left_key   (lk),
            .left_lt    (llt),
            .right_valid(rv),
            .right_key  (rk),
            .valid_reg  (cell_valid[i]),
            .key_reg    (cell_key[i]),
            .lt         (cell_lt[i]),
            .red        (red_all[i])
        );
    end

    // Pad the last group with empty contributions.
    for (genvar i = CAPACITY; i < NGROUP * GROUP; i++)
    begin : g_pad
        assign red_all[i] = '0;
    end

    // ---------------------------------------------------------------
    // Two-level OR tree: groups of cells, then all groups
    // ---------------------------------------------------------------
    for (genvar g = 0; g < NGROUP; g++)
    begin : g_group
        ost_group #(
            .NUM(GROUP)
        ) u_group (
            .clk    (clk),
            .parts  (red_all[g*GROUP +: GROUP]),
            .sum_reg(grp_sum[g])
        );
    end

    // Every stored key smaller than the probe: count is the capacity itself.
    always_comb
    begin
        tail_next.present = 1'b0;
        tail_next.sel_ok  = 1'b0;
        if ((cmd_reg == CMD_COUNT) && cell_lt[CAPACITY-1])
        begin
            tail_next.ans = KEY_W'(CAPACITY);
        end
        else
        begin
            tail_next.ans = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
    end

    assign grp_sum[NGROUP] = tail_reg;

    ost_group #(
        .NUM(NGROUP + 1)
    ) u_total (
        .clk    (clk),
        .parts  (grp_sum),
        .sum_reg(total)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign full     = cell_valid[CAPACITY-1];
    assign req.ready = (state_reg == S_IDLE);
    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        case (cmd_reg)
            CMD_INSERT: need_out = !total.present && full;
            CMD_DELETE: need_out = 1'b0;
            CMD_COUNT:  need_out = 1'b1;
            CMD_SELECT: need_out = 1'b1;
            default:    need_out = 1'b0;
        endcase
    end

    // Hold in the update state while a result still waits, if this item needs it.
    assign advance  = (state_reg == S_APPLY) && (!need_out || out_free);
    assign ctrl.ins = advance && (cmd_reg == CMD_INSERT) && !total.present && !full;
    assign ctrl.del = advance && (cmd_reg == CMD_DELETE) && total.present;

    always_comb
    begin
        case (state_reg)
            S_IDLE:   state_next = accept ? S_SCAN : S_IDLE;
            S_SCAN:   state_next = S_REDUCE;
            S_REDUCE: state_next = S_APPLY;
            S_APPLY:  state_next = advance ? S_IDLE : S_APPLY;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= ost_cmd_t'(req.cmd);
            probe_reg <= req.key;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        answer_next    = answer_reg;
        status_next    = status_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (advance && need_out)
        begin
            rsp_valid_next = 1'b1;
            case (cmd_reg)
                CMD_COUNT:
                begin
                    answer_next = total.ans;
                    status_next = ST_OK;
                end
                CMD_SELECT:
                begin
                    if (total.sel_ok)
                    begin
                        answer_next = total.ans;
                        status_next = ST_OK;
                    end
                    else
                    begin
                        answer_next = '0;
                        status_next = ST_BADPOS;
                    end
                end
                default:
                begin
                    answer_next = '0;
                    status_next = ST_FULL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
        status_reg <= status_next;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.answer = answer_reg;
    assign rsp.status = status_reg;

    `OST_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready)
    `OST_ASSERT(a_ins_nonempty, ctrl.ins |=> cell_valid[0])
    `OST_ASSERT(a_del_not_full, ctrl.del |=> !cell_valid[CAPACITY-1])

endmodule
